/* design/hsvrgb_pkg.sv */
// Shared constants, types and helpers for the HSV to RGB converter.
// No dependencies; imported by hsvrgb_hue_path, hsv_to_rgb_converter and the testbench.
package hsvrgb_pkg;

  // Fixed field widths
  localparam int IN_W  = 16;
  localparam int OUT_W = 15;

  // Default fixed-point formats
  localparam int UNIT_FRAC_BITS_DEF = 14;
  localparam int HUE_FRAC_BITS_DEF  = 4;

  // Angles in whole degrees
  localparam int DEG_TURN   = 360;
  localparam int DEG_SECTOR = 60;

  // Pipeline shape
  localparam int HUE_STAGES = 6;
  localparam int NUM_STAGES = 11;

  // 60-degree sector codes, named by the hue at the sector start
  typedef logic [2:0] sector_t;
  localparam sector_t SECT_RED     = 3'd0;
  localparam sector_t SECT_YELLOW  = 3'd1;
  localparam sector_t SECT_GREEN   = 3'd2;
  localparam sector_t SECT_CYAN    = 3'd3;
  localparam sector_t SECT_BLUE    = 3'd4;
  localparam sector_t SECT_MAGENTA = 3'd5;

  // Bits needed for a ramp position 0..sector inclusive
  function automatic int ramp_w(input int hue_frac);
    return $clog2((DEG_SECTOR << hue_frac) + 1);
  endfunction

endpackage

/* design/hsvrgb_hue_path.sv */
// Hue pipeline: wraps the hue into one turn, then splits it into sector and ramp.
// Depends on hsvrgb_pkg; instantiated by hsv_to_rgb_converter.
module hsvrgb_hue_path #(
  parameter int HUE_FRAC_BITS = hsvrgb_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                                            clk,
  input  logic [hsvrgb_pkg::HUE_STAGES-1:0]               stage_en,
  input  logic signed [hsvrgb_pkg::IN_W-1:0]              hue,
  output hsvrgb_pkg::sector_t                             sector,
  output logic [hsvrgb_pkg::ramp_w(HUE_FRAC_BITS)-1:0]    ramp_k
);
  import hsvrgb_pkg::*;

  localparam int TURN     = DEG_TURN << HUE_FRAC_BITS;
  localparam int SECTOR   = DEG_SECTOR << HUE_FRAC_BITS;
  localparam int HUE_SPAN = 1 << (IN_W - 1);
  // Whole turns added so the hue is never negative
  localparam int OFFSET   = ((HUE_SPAN + TURN - 1) / TURN) * TURN;
  localparam int U_W      = $clog2(OFFSET + HUE_SPAN);
  // Reciprocal of one turn; estimate is low by at most one turn
  localparam int RECIP    = (1 << U_W) / TURN;
  localparam int RECIP_W  = $clog2(RECIP + 1);
  localparam int QP_W     = U_W + RECIP_W;
  localparam int R_W      = $clog2(TURN);
  localparam int POS_W    = ramp_w(HUE_FRAC_BITS);

  logic [U_W-1:0]     u0_r, u1_r;
  logic [RECIP_W-1:0] q1_r;
  logic [R_W:0]       r2_r;
  logic [R_W-1:0]     r3_r;
  sector_t            sect4_r, sect5_r;
  logic [POS_W-1:0]   pos4_r, k5_r;

  logic [QP_W-1:0]    qprod;
  logic [RECIP_W-1:0] q1_nxt;
  logic [U_W-1:0]     qturn;
  logic [R_W:0]       r2_nxt;
  logic [R_W-1:0]     r3_nxt;
  sector_t            sect4_nxt;
  logic [POS_W-1:0]   pos4_nxt, k5_nxt;

  // Stage 1: quotient estimate by reciprocal
  assign qprod  = QP_W'(u0_r) * QP_W'(RECIP);
  assign q1_nxt = RECIP_W'(qprod >> U_W);

  // Stage 2: remainder, below two turns
  assign qturn  = U_W'(q1_r) * U_W'(TURN);
  assign r2_nxt = (R_W + 1)'(u1_r - qturn);

  // Stage 3: final correction into one turn
  assign r3_nxt = (r2_r >= (R_W + 1)'(TURN)) ? R_W'(r2_r - (R_W + 1)'(TURN)) : R_W'(r2_r);

  // Stage 4: sector and position within it
  always_comb begin
    priority if (r3_r >= R_W'(5 * SECTOR)) begin
      sect4_nxt = SECT_MAGENTA;
      pos4_nxt  = POS_W'(r3_r - R_W'(5 * SECTOR));
    end else if (r3_r >= R_W'(4 * SECTOR)) begin
      sect4_nxt = SECT_BLUE;
      pos4_nxt  = POS_W'(r3_r - R_W'(4 * SECTOR));
    end else if (r3_r >= R_W'(3 * SECTOR)) begin
      sect4_nxt = SECT_CYAN;
      pos4_nxt  = POS_W'(r3_r - R_W'(3 * SECTOR));
    end else if (r3_r >= R_W'(2 * SECTOR)) begin
      sect4_nxt = SECT_GREEN;
      pos4_nxt  = POS_W'(r3_r - R_W'(2 * SECTOR));
    end else if (r3_r >= R_W'(SECTOR)) begin
      sect4_nxt = SECT_YELLOW;
      pos4_nxt  = POS_W'(r3_r - R_W'(SECTOR));
    end else begin
      sect4_nxt = SECT_RED;
      pos4_nxt  = POS_W'(r3_r);
    end
  end

  // Stage 5: falling sectors (odd codes) ramp down
  assign k5_nxt = sect4_r[0] ? (POS_W'(SECTOR) - pos4_r) : pos4_r;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      u0_r <= U_W'(32'(hue) + OFFSET);
    end
    if (stage_en[1]) begin
      q1_r <= q1_nxt;
      u1_r <= u0_r;
    end
    if (stage_en[2]) begin
      r2_r <= r2_nxt;
    end
    if (stage_en[3]) begin
      r3_r <= r3_nxt;
    end
    if (stage_en[4]) begin
      sect4_r <= sect4_nxt;
      pos4_r  <= pos4_nxt;
    end
    if (stage_en[5]) begin
      sect5_r <= sect4_r;
      k5_r    <= k5_nxt;
    end
  end

  assign sector = sect5_r;
  assign ramp_k = k5_r;

endmodule

/* design/hsv_to_rgb_converter.sv */
// HSV with alpha to RGB with alpha, fixed point. Each accepted input transaction
// passes through 11 register stages to out_valid; each stage holds one item.
// Throughput: one transaction per clock while not stalled; each stage advances when it or a
// later stage is empty or out_ready is high, so bubbles close up under stall.
// Reset (rst_n, synchronous) clears the stage valid bits only.
// Depends on hsvrgb_pkg and hsvrgb_hue_path.
module hsv_to_rgb_converter #(
  parameter int UNIT_FRAC_BITS = hsvrgb_pkg::UNIT_FRAC_BITS_DEF,
  parameter int HUE_FRAC_BITS  = hsvrgb_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [hsvrgb_pkg::IN_W-1:0] in_hue,
  input  logic signed [hsvrgb_pkg::IN_W-1:0] in_saturation,
  input  logic signed [hsvrgb_pkg::IN_W-1:0] in_value_level,
  input  logic signed [hsvrgb_pkg::IN_W-1:0] in_alpha_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [hsvrgb_pkg::OUT_W-1:0]       out_red,
  output logic [hsvrgb_pkg::OUT_W-1:0]       out_green,
  output logic [hsvrgb_pkg::OUT_W-1:0]       out_blue,
  output logic [hsvrgb_pkg::OUT_W-1:0]       out_alpha_out
);
  import hsvrgb_pkg::*;

  localparam int UNIT_ONE   = 1 << UNIT_FRAC_BITS;
  localparam int UNIT_W     = UNIT_FRAC_BITS + 1;
  localparam int HALF_UNIT  = 1 << (UNIT_FRAC_BITS - 1);
  localparam int PROD_W     = 2 * UNIT_W;
  localparam int SECTOR     = DEG_SECTOR << HUE_FRAC_BITS;
  localparam int POS_W      = ramp_w(HUE_FRAC_BITS);
  localparam int P_W        = UNIT_W + POS_W;
  // Sector is an odd factor times a power of two: shift, then divide by the odd part
  localparam int RAMP_SHIFT = HUE_FRAC_BITS + 2;
  localparam int RAMP_ODD   = SECTOR >> RAMP_SHIFT;
  localparam int RAMP_HALF  = SECTOR / 2;
  localparam int W_W        = UNIT_W + 3;
  localparam int RRECIP     = (1 << W_W) / RAMP_ODD;
  localparam int RRECIP_W   = $clog2(RRECIP + 1);
  localparam int DP_W       = W_W + RRECIP_W;
  localparam int SUM_X_W    = (UNIT_W > OUT_W) ? UNIT_W : OUT_W;
  localparam int MIX_FIRST  = 3;
  localparam int SECT_FIRST = HUE_STAGES;
  localparam int LAST       = NUM_STAGES - 1;

  // Values carried alongside the ramp math
  typedef struct packed {
    logic [UNIT_W-1:0] chroma;
    logic [UNIT_W-1:0] offset;
    logic [UNIT_W-1:0] alpha;
  } mix_t;

  function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [IN_W-1:0] x);
    logic [UNIT_W-1:0] y;
    if (x < 0) begin
      y = '0;
    end else if (32'(x) > UNIT_ONE) begin
      y = UNIT_W'(UNIT_ONE);
    end else begin
      y = UNIT_W'(x);
    end
    return y;
  endfunction

  logic [NUM_STAGES-1:0] stage_en;
  logic [NUM_STAGES-1:0] valid_r;

  logic [UNIT_W-1:0]  sat0_r, val0_r, alp0_r;
  logic [PROD_W-1:0]  prod1_r;
  logic [UNIT_W-1:0]  val1_r, alp1_r;
  logic [UNIT_W-1:0]  chr2_r, val2_r, alp2_r;
  mix_t               mix_r [MIX_FIRST:LAST-1];
  sector_t            sect_r [SECT_FIRST:LAST-1];
  logic [P_W-1:0]     p6_r;
  logic [W_W-1:0]     w7_r, w8_r;
  logic [UNIT_W-1:0]  qe8_r, x9_r;
  logic [OUT_W-1:0]   red_r, green_r, blue_r, alpha_r;

  sector_t            hue_sector;
  logic [POS_W-1:0]   hue_k;
  logic [PROD_W-1:0]  prod1_nxt, csum;
  logic [UNIT_W-1:0]  chr2_nxt;
  mix_t               mix3_nxt;
  logic [P_W-1:0]     p6_nxt;
  logic [P_W:0]       psum;
  logic [W_W-1:0]     w7_nxt;
  logic [DP_W-1:0]    dprod;
  logic [UNIT_W-1:0]  qe8_nxt;
  logic [W_W-1:0]     back, rem;
  logic [UNIT_W-1:0]  x9_nxt;
  logic [UNIT_W-1:0]  red_pre, green_pre, blue_pre;
  logic [SUM_X_W-1:0] red_x, green_x, blue_x, alpha_x;

  // Stage advance: move when this or any later stage is empty, or output drains
  for (genvar gi = 0; gi < NUM_STAGES; gi++) begin : g_en
    assign stage_en[gi] = out_ready || !(&valid_r[LAST:gi]);
  end

  assign in_ready  = stage_en[0];
  assign out_valid = valid_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (stage_en[i]) begin
          valid_r[i] <= valid_r[i-1];
        end
      end
    end
  end

  // Hue wrap and sector split, stages 0 to 5
  hsvrgb_hue_path #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_hue_path (
    .clk      (clk),
    .stage_en (stage_en[HUE_STAGES-1:0]),
    .hue      (in_hue),
    .sector   (hue_sector),
    .ramp_k   (hue_k)
  );

  // Chroma = V*S rounded half up, offset M = V - C
  assign prod1_nxt       = PROD_W'(val0_r) * PROD_W'(sat0_r);
  assign csum            = prod1_r + PROD_W'(HALF_UNIT);
  assign chr2_nxt        = UNIT_W'(csum >> UNIT_FRAC_BITS);
  assign mix3_nxt.chroma = chr2_r;
  assign mix3_nxt.offset = val2_r - chr2_r;
  assign mix3_nxt.alpha  = alp2_r;

  // Ramp X = (C*k + sector/2) / sector
  assign p6_nxt  = P_W'(mix_r[5].chroma) * P_W'(hue_k);
  assign psum    = (P_W + 1)'(p6_r) + (P_W + 1)'(RAMP_HALF);
  assign w7_nxt  = W_W'(psum >> RAMP_SHIFT);
  assign dprod   = DP_W'(w7_r) * DP_W'(RRECIP);
  assign qe8_nxt = UNIT_W'(dprod >> W_W);
  assign back    = W_W'(qe8_r) * W_W'(RAMP_ODD);
  assign rem     = w8_r - back;
  assign x9_nxt  = (rem >= W_W'(RAMP_ODD)) ? (qe8_r + UNIT_W'(1)) : qe8_r;

  // Channel pick by sector, then add the offset
  always_comb begin
    unique case (sect_r[LAST-1])
      SECT_RED: begin
        red_pre = mix_r[LAST-1].chroma; green_pre = x9_r; blue_pre = '0;
      end
      SECT_YELLOW: begin
        red_pre = x9_r; green_pre = mix_r[LAST-1].chroma; blue_pre = '0;
      end
      SECT_GREEN: begin
        red_pre = '0; green_pre = mix_r[LAST-1].chroma; blue_pre = x9_r;
      end
      SECT_CYAN: begin
        red_pre = '0; green_pre = x9_r; blue_pre = mix_r[LAST-1].chroma;
      end
      SECT_BLUE: begin
        red_pre = x9_r; green_pre = '0; blue_pre = mix_r[LAST-1].chroma;
      end
      default: begin
        red_pre = mix_r[LAST-1].chroma; green_pre = '0; blue_pre = x9_r;
      end
    endcase
  end

  assign red_x   = SUM_X_W'(red_pre + mix_r[LAST-1].offset);
  assign green_x = SUM_X_W'(green_pre + mix_r[LAST-1].offset);
  assign blue_x  = SUM_X_W'(blue_pre + mix_r[LAST-1].offset);
  assign alpha_x = SUM_X_W'(mix_r[LAST-1].alpha);

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      sat0_r <= clamp_unit(in_saturation);
      val0_r <= clamp_unit(in_value_level);
      alp0_r <= clamp_unit(in_alpha_in);
    end
    if (stage_en[1]) begin
      prod1_r <= prod1_nxt;
      val1_r  <= val0_r;
      alp1_r  <= alp0_r;
    end
    if (stage_en[2]) begin
      chr2_r <= chr2_nxt;
      val2_r <= val1_r;
      alp2_r <= alp1_r;
    end
    if (stage_en[MIX_FIRST]) begin
      mix_r[MIX_FIRST] <= mix3_nxt;
    end
    for (int i = MIX_FIRST + 1; i < LAST; i++) begin
      if (stage_en[i]) begin
        mix_r[i] <= mix_r[i-1];
      end
    end
    if (stage_en[SECT_FIRST]) begin
      sect_r[SECT_FIRST] <= hue_sector;
      p6_r               <= p6_nxt;
    end
    for (int i = SECT_FIRST + 1; i < LAST; i++) begin
      if (stage_en[i]) begin
        sect_r[i] <= sect_r[i-1];
      end
    end
    if (stage_en[7]) begin
      w7_r <= w7_nxt;
    end
    if (stage_en[8]) begin
      qe8_r <= qe8_nxt;
      w8_r  <= w7_r;
    end
    if (stage_en[9]) begin
      x9_r <= x9_nxt;
    end
    if (stage_en[LAST]) begin
      red_r   <= red_x[OUT_W-1:0];
      green_r <= green_x[OUT_W-1:0];
      blue_r  <= blue_x[OUT_W-1:0];
      alpha_r <= alpha_x[OUT_W-1:0];
    end
  end

  assign out_red       = red_r;
  assign out_green     = green_r;
  assign out_blue      = blue_r;
  assign out_alpha_out = alpha_r;

endmodule

/* tb/hsv_to_rgb_converter_test.sv */
// Self-checking testbench for hsv_to_rgb_converter: directed corner colors, then random
// streams under sender gaps and receiver stalls, checked against a built-in color predictor.
// Depends on hsvrgb_pkg and the converter RTL.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_test;
  import hsvrgb_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int UNIT_FRAC       = UNIT_FRAC_BITS_DEF;
  localparam int HUE_FRAC        = HUE_FRAC_BITS_DEF;
  localparam int UNIT_ONE        = 1 << UNIT_FRAC;
  localparam int HUE_TURN        = DEG_TURN << HUE_FRAC;
  localparam int HUE_SECTOR      = DEG_SECTOR << HUE_FRAC;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
    logic [OUT_W-1:0] alpha;
  } rgba_t;

  typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_SPARSE, RDY_PATTERN} ready_mode_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [IN_W-1:0]  in_hue;
  logic signed [IN_W-1:0]  in_saturation;
  logic signed [IN_W-1:0]  in_value_level;
  logic signed [IN_W-1:0]  in_alpha_in;
  logic                    out_valid;
  logic                    out_ready;
  logic [OUT_W-1:0]        out_red;
  logic [OUT_W-1:0]        out_green;
  logic [OUT_W-1:0]        out_blue;
  logic [OUT_W-1:0]        out_alpha_out;

  rgba_t       rgba_expected[$];
  int          fail_count    = 0;
  int          burst_left    = 0;
  bit          sender_steady = 1'b1;
  bit          hold_off_req  = 1'b0;
  ready_mode_t ready_mode    = RDY_ALWAYS;

  hsv_to_rgb_converter #(
    .UNIT_FRAC_BITS(UNIT_FRAC),
    .HUE_FRAC_BITS (HUE_FRAC)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_value_level(in_value_level),
    .in_alpha_in   (in_alpha_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha_out (out_alpha_out)
  );

  // Clock
  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Clamp a signed Q2.14 level into 0..1.0
  function automatic int clamp_unit(input logic signed [IN_W-1:0] raw);
    int lvl;
    lvl = int'(raw);
    if (lvl < 0) return 0;
    if (lvl > UNIT_ONE) return UNIT_ONE;
    return lvl;
  endfunction

  // Expected RGBA for one HSV+alpha transaction
  function automatic rgba_t predict_rgba(input logic signed [IN_W-1:0] hue, sat, val, alpha);
    int      wrapped;
    int      pos;
    int      ramp_k;
    longint  s_lvl, v_lvl, chroma, ramp, offset;
    longint  r_sum, g_sum, b_sum;
    sector_t sect;
    rgba_t   res;
    wrapped = int'(hue) % HUE_TURN;
    if (wrapped < 0) wrapped += HUE_TURN;
    sect   = sector_t'(wrapped / HUE_SECTOR);
    pos    = wrapped % HUE_SECTOR;
    s_lvl  = clamp_unit(sat);
    v_lvl  = clamp_unit(val);
    // chroma rounded half up, ramp rises in even sectors and falls in odd ones
    chroma = (v_lvl * s_lvl + (longint'(1) << (UNIT_FRAC - 1))) >> UNIT_FRAC;
    ramp_k = sect[0] ? (HUE_SECTOR - pos) : pos;
    ramp   = (chroma * ramp_k + HUE_SECTOR / 2) / HUE_SECTOR;
    offset = v_lvl - chroma;
    case (sect)
      SECT_RED: begin
        r_sum = chroma; g_sum = ramp;   b_sum = 0;
      end
      SECT_YELLOW: begin
        r_sum = ramp;   g_sum = chroma; b_sum = 0;
      end
      SECT_GREEN: begin
        r_sum = 0;      g_sum = chroma; b_sum = ramp;
      end
      SECT_CYAN: begin
        r_sum = 0;      g_sum = ramp;   b_sum = chroma;
      end
      SECT_BLUE: begin
        r_sum = ramp;   g_sum = 0;      b_sum = chroma;
      end
      default: begin  // magenta
        r_sum = chroma; g_sum = 0;      b_sum = ramp;
      end
    endcase
    r_sum     = r_sum + offset;
    g_sum     = g_sum + offset;
    b_sum     = b_sum + offset;
    res.red   = r_sum[OUT_W-1:0];
    res.green = g_sum[OUT_W-1:0];
    res.blue  = b_sum[OUT_W-1:0];
    res.alpha = OUT_W'(clamp_unit(alpha));
    return res;
  endfunction

  // Random hue: near sector edges with a few turns added, in one turn, or any 16 bits
  function automatic logic signed [IN_W-1:0] rand_hue();
    int raw;
    case ($urandom_range(0, 3))
      0: raw = HUE_SECTOR * int'($urandom_range(0, 6)) + int'($urandom_range(0, 2)) - 1
               + HUE_TURN * (int'($urandom_range(0, 6)) - 3);
      1: raw = int'($urandom_range(0, HUE_TURN - 1));
      default: raw = int'($urandom);
    endcase
    return raw[IN_W-1:0];
  endfunction

  // Random level: mostly in range, with edges, over-range, negatives and raw bits
  function automatic logic signed [IN_W-1:0] rand_unit();
    int raw;
    case ($urandom_range(0, 9))
      0: raw = 0;
      1: raw = UNIT_ONE;
      2: raw = UNIT_ONE + int'($urandom_range(1, 16383));
      3: raw = -int'($urandom_range(1, 32768));
      4: raw = int'($urandom);
      default: raw = int'($urandom_range(0, UNIT_ONE));
    endcase
    return raw[IN_W-1:0];
  endfunction

  // Drive one transaction; entered and left at a falling edge
  task automatic send_color(input logic signed [IN_W-1:0] hue, sat, val, alpha);
    int gap;
    if (!sender_steady && burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid       <= 1'b1;
    in_hue         <= hue;
    in_saturation  <= sat;
    in_value_level <= val;
    in_alpha_in    <= alpha;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rgba_expected.push_back(predict_rgba(hue, sat, val, alpha));
    if (burst_left > 0) burst_left--;
    @(negedge clk);
  endtask

  task automatic send_random_colors(input int count);
    for (int i = 0; i < count; i++)
      send_color(rand_hue(), rand_unit(), rand_unit(), rand_unit());
  endtask

  // Each sector start, the last step of the turn, full and negative turns, plus negative and mid-sector hues
  task automatic test_sector_corners();
    sender_steady = 1'b1;
    ready_mode    = RDY_ALWAYS;
    for (int sct = 0; sct < 6; sct++)
      send_color(IN_W'(sct * HUE_SECTOR), IN_W'(UNIT_ONE), IN_W'(UNIT_ONE), IN_W'(UNIT_ONE));
    send_color(IN_W'(HUE_TURN - 1), IN_W'(UNIT_ONE), IN_W'(12000), IN_W'(UNIT_ONE));
    send_color(IN_W'(HUE_TURN), IN_W'(UNIT_ONE), IN_W'(UNIT_ONE), IN_W'(8192));
    send_color(-16'sd1, IN_W'(UNIT_ONE), IN_W'(UNIT_ONE), IN_W'(8192));
    send_color(IN_W'(-2 * HUE_TURN), IN_W'(UNIT_ONE), IN_W'(UNIT_ONE), IN_W'(4096));
    send_color(IN_W'(-5000), IN_W'(8192), IN_W'(16385), -16'sd1);
    send_color(IN_W'(4320), IN_W'(12345), IN_W'(9876), IN_W'(UNIT_ONE));
  endtask

  // Clamping of levels, grey from zero saturation and from chroma rounding to zero
  task automatic test_clamping();
    send_color(-16'sd32768, IN_W'(UNIT_ONE), IN_W'(UNIT_ONE), 16'sd32767);
    send_color(16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768);
    send_color(IN_W'(480), -16'sd32768, IN_W'(12000), IN_W'(8000));
    send_color(IN_W'(1440), 16'sd0, IN_W'(UNIT_ONE), 16'sd0);
    send_color(IN_W'(2400), 16'sd1, 16'sd1, IN_W'(UNIT_ONE - 1));
    send_color(IN_W'(3000), IN_W'(UNIT_ONE), -16'sd32768, IN_W'(UNIT_ONE + 1));
    send_color(16'sd0, 16'sd0, 16'sd0, 16'sd0);
  endtask

  task automatic test_random_streaming();
    sender_steady = 1'b1;
    ready_mode    = RDY_ALWAYS;
    send_random_colors(100);
  endtask

  task automatic test_random_bursty();
    sender_steady = 1'b0;
    ready_mode    = RDY_MOSTLY;
    send_random_colors(120);
    ready_mode    = RDY_SPARSE;
    send_random_colors(80);
  endtask

  task automatic test_random_patterned();
    sender_steady = 1'b0;
    ready_mode    = RDY_PATTERN;
    send_random_colors(150);
  endtask

  // Long receiver hold-off while the sender keeps offering, so the pipe fills
  task automatic test_backpressure();
    sender_steady = 1'b1;
    ready_mode    = RDY_MOSTLY;
    hold_off_req  = 1'b1;
    send_random_colors(50);
  endtask

  // Receiver: per-mode stall pattern, plus a long hold-off on request
  initial begin
    int         tick;
    logic [7:0] pattern;
    out_ready = 1'b0;
    tick      = 0;
    pattern   = 8'b1011_0110;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        case (ready_mode)
          RDY_ALWAYS:  out_ready <= 1'b1;
          RDY_MOSTLY:  out_ready <= ($urandom_range(0, 9) < 8);
          RDY_SPARSE:  out_ready <= ($urandom_range(0, 9) < 3);
          default:     out_ready <= pattern[tick % 8];
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [OUT_W-1:0] want, got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Result checker: every accepted transaction against the oldest expectation
  always @(posedge clk) begin
    rgba_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rgba_expected.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d alpha %0d",
               out_red, out_green, out_blue, out_alpha_out);
        fail_count++;
      end else begin
        want = rgba_expected.pop_front();
        check_field("red", want.red, out_red);
        check_field("green", want.green, out_green);
        check_field("blue", want.blue, out_blue);
        check_field("alpha_out", want.alpha, out_alpha_out);
      end
    end
  end

  // Test sequence
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_hue         = '0;
    in_saturation  = '0;
    in_value_level = '0;
    in_alpha_in    = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_sector_corners();
    test_clamping();
    test_random_streaming();
    test_random_bursty();
    test_backpressure();
    test_random_patterned();
    in_valid <= 1'b0;

    // drain, then watch for stray results
    while (rgba_expected.size() != 0) @(posedge clk);
    ready_mode = RDY_ALWAYS;
    repeat (NUM_STAGES + 20) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
